// ===== rtl/aeg_pkg.sv =====
// ----------------------------------------------------------------------------
// aeg_pkg
// Shared types and constants for the ADSR envelope gain block: register
// indexes and reset values, MIDI decode constants, stage encoding.
// ----------------------------------------------------------------------------
package aeg_pkg;

  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int LEVEL_FRAC_BITS_DEF = 23;

  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int TALLY_W     = 16;
  localparam int STAGE_W     = 3;
  localparam int MQ_DEPTH    = 4;
  localparam int OQ_DEPTH    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP  = 2'd3;

  localparam logic [CFG_W-1:0] ATTACK_STEP_RST   = 24'd8388;
  localparam logic [CFG_W-1:0] DECAY_STEP_RST    = 24'd4194;
  localparam logic [CFG_W-1:0] SUSTAIN_LEVEL_RST = 24'd4194304;
  localparam logic [CFG_W-1:0] RELEASE_STEP_RST  = 24'd4194;

  localparam logic [7:0] MIDI_TYPE_MASK = 8'hF0;
  localparam logic [7:0] MIDI_NOTE_ON   = 8'h90;
  localparam logic [7:0] MIDI_NOTE_OFF  = 8'h80;

  localparam logic [STAGE_W-1:0] CODE_ATTACK  = 3'd0;
  localparam logic [STAGE_W-1:0] CODE_DECAY   = 3'd1;
  localparam logic [STAGE_W-1:0] CODE_SUSTAIN = 3'd2;
  localparam logic [STAGE_W-1:0] CODE_RELEASE = 3'd3;
  localparam logic [STAGE_W-1:0] CODE_IDLE    = 3'd4;

  typedef enum logic [4:0] {
    ST_ATTACK  = 5'b00001,
    ST_DECAY   = 5'b00010,
    ST_SUSTAIN = 5'b00100,
    ST_RELEASE = 5'b01000,
    ST_IDLE    = 5'b10000
  } stage_t;

  typedef struct packed {
    logic [CFG_W-1:0] attack_step;
    logic [CFG_W-1:0] decay_step;
    logic [CFG_W-1:0] sustain_level;
    logic [CFG_W-1:0] release_step;
  } aeg_cfg_t;

  function automatic logic [STAGE_W-1:0] stage_code(input stage_t st);
    logic [STAGE_W-1:0] code;
    case (st)
      ST_ATTACK:  code = CODE_ATTACK;
      ST_DECAY:   code = CODE_DECAY;
      ST_SUSTAIN: code = CODE_SUSTAIN;
      ST_RELEASE: code = CODE_RELEASE;
      default:    code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/adsr_envelope_gain.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_gain
// Linear ADSR envelope that scales an audio stream by its level.
//
// Input channel (in_push / in_full): each item is an audio sample
// (in_operation 0) or a MIDI message (in_operation 1). MIDI items only update
// the note tally and produce no result; each sample produces one result.
// Result channel (out_empty / out_pop): scaled sample, stage and level after
// the step, oldest first.
// Configuration (cfg_we / cfg_index / cfg_wdata): attack step, decay step,
// sustain level, release step; registered writes, no read-back.
// Path: an accepted sample passes the sample queue, the multiply register
// and the result queue, in that order, before it reaches the result ports.
// Throughput: one item per cycle while in_full is low; each sample gets
// one envelope step and one multiply.
// Reset: registers return to their defaults, stage idle, level and tally zero,
// both queues empty. When the receiver stalls the result queue fills, then
// the product stage and sample queue, and in_full rises.
// ----------------------------------------------------------------------------
module adsr_envelope_gain #(
  parameter int SAMPLE_BITS     = aeg_pkg::SAMPLE_BITS_DEF,
  parameter int LEVEL_FRAC_BITS = aeg_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_operation,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_in,
  input  logic [7:0]                        in_midi_status,
  input  logic [6:0]                        in_midi_velocity,
  input  logic                              in_message_complete,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [SAMPLE_BITS-1:0]     out_sample_out,
  output logic [aeg_pkg::STAGE_W-1:0]       out_stage_out,
  output logic [LEVEL_FRAC_BITS:0]          out_level_out,
  input  logic                              cfg_we,
  input  logic [aeg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aeg_pkg::CFG_W-1:0]         cfg_wdata
);
  import aeg_pkg::*;

  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam int QW = SAMPLE_BITS + STAGE_W + LW;

  aeg_cfg_t                    cfg_r;
  logic                        in_acc;
  logic                        f_push;
  logic signed [SAMPLE_BITS-1:0] f_sample, mq_sample, b_sample;
  logic [STAGE_W-1:0]          f_code, mq_code, b_code;
  logic [LW-1:0]               f_level, mq_level, b_level;
  logic [QW-1:0]               mq_wdata, mq_rdata, oq_wdata, oq_rdata;
  logic                        mq_empty, mq_pop;
  logic                        oq_full, oq_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_step   <= ATTACK_STEP_RST;
      cfg_r.decay_step    <= DECAY_STEP_RST;
      cfg_r.sustain_level <= SUSTAIN_LEVEL_RST;
      cfg_r.release_step  <= RELEASE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK_STEP:   cfg_r.attack_step   <= cfg_wdata;
        CFG_DECAY_STEP:    cfg_r.decay_step    <= cfg_wdata;
        CFG_SUSTAIN_LEVEL: cfg_r.sustain_level <= cfg_wdata;
        CFG_RELEASE_STEP:  cfg_r.release_step  <= cfg_wdata;
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_acc = in_push && !in_full;

  aeg_front #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .item_vld      (in_acc),
    .item_op       (in_operation),
    .item_sample   (in_sample_in),
    .item_status   (in_midi_status),
    .item_velocity (in_midi_velocity),
    .item_complete (in_message_complete),
    .mq_push       (f_push),
    .mq_sample     (f_sample),
    .mq_code       (f_code),
    .mq_level      (f_level)
  );

  assign mq_wdata = {f_sample, f_code, f_level};
  assign {mq_sample, mq_code, mq_level} = mq_rdata;

  aeg_fifo #(
    .WIDTH (QW),
    .DEPTH (MQ_DEPTH)
  ) u_mq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (mq_wdata),
    .full  (in_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  aeg_back #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mq_empty  (mq_empty),
    .mq_sample (mq_sample),
    .mq_code   (mq_code),
    .mq_level  (mq_level),
    .mq_pop    (mq_pop),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_sample (b_sample),
    .oq_code   (b_code),
    .oq_level  (b_level)
  );

  assign oq_wdata = {b_sample, b_code, b_level};
  assign {out_sample_out, out_stage_out, out_level_out} = oq_rdata;

  aeg_fifo #(
    .WIDTH (QW),
    .DEPTH (OQ_DEPTH)
  ) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty)
  );

endmodule

// ===== rtl/aeg_fifo.sv =====
// ----------------------------------------------------------------------------
// aeg_fifo
// Small register-based queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module aeg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/aeg_front.sv =====
// ----------------------------------------------------------------------------
// aeg_front
// Item front end: decodes MIDI messages into the note tally, applies the
// tally at each sample and steps the envelope, then queues the sample with
// its new stage and level.
// ----------------------------------------------------------------------------
module aeg_front #(
  parameter int SAMPLE_BITS     = aeg_pkg::SAMPLE_BITS_DEF,
  parameter int LEVEL_FRAC_BITS = aeg_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  aeg_pkg::aeg_cfg_t               cfg,
  input  logic                            item_vld,
  input  logic                            item_op,
  input  logic signed [SAMPLE_BITS-1:0]   item_sample,
  input  logic [7:0]                      item_status,
  input  logic [6:0]                      item_velocity,
  input  logic                            item_complete,
  output logic                            mq_push,
  output logic signed [SAMPLE_BITS-1:0]   mq_sample,
  output logic [aeg_pkg::STAGE_W-1:0]     mq_code,
  output logic [LEVEL_FRAC_BITS:0]        mq_level
);
  import aeg_pkg::*;

  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam int AW = ((LW > CFG_W) ? LW : CFG_W) + 2;
  localparam logic [LW-1:0] LVL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic signed [AW-1:0] ONE_X = AW'(LVL_ONE);
  localparam logic signed [2:0] DELTA_UP   = 3'sd1;
  localparam logic signed [2:0] DELTA_DOWN = -3'sd2;
  localparam logic signed [2:0] DELTA_NONE = 3'sd0;

  stage_t                     stage_r, stage_nxt, stage_a;
  logic [LW-1:0]              level_r, level_nxt, level_a;
  logic signed [TALLY_W-1:0]  tally_r, tally_nxt, tally_sat;
  logic signed [TALLY_W:0]    tally_sum;
  logic signed [2:0]          delta;
  logic [7:0]                 msg_type;
  logic signed [AW-1:0]       lvl_x, sus_raw, sus_x, atk_sum, dec_diff, rel_diff;
  logic                       tally_pos, tally_neg;

  assign msg_type  = item_status & MIDI_TYPE_MASK;
  assign tally_pos = !tally_r[TALLY_W-1] && (tally_r != '0);
  assign tally_neg = tally_r[TALLY_W-1];

  always_comb begin
    delta = DELTA_NONE;
    if (item_complete) begin
      if (msg_type == MIDI_NOTE_ON && item_velocity != '0) begin
        delta = DELTA_UP;
      end else if (msg_type == MIDI_NOTE_OFF || msg_type == MIDI_NOTE_ON) begin
        delta = DELTA_DOWN;
      end
    end
  end

  always_comb begin
    tally_sum = {tally_r[TALLY_W-1], tally_r} + (TALLY_W + 1)'(delta);
    if (tally_sum[TALLY_W] != tally_sum[TALLY_W-1]) begin
      tally_sat = tally_sum[TALLY_W] ? {1'b1, {(TALLY_W-1){1'b0}}}
                                     : {1'b0, {(TALLY_W-1){1'b1}}};
    end else begin
      tally_sat = tally_sum[TALLY_W-1:0];
    end
  end

  always_comb begin
    stage_a = stage_r;
    level_a = level_r;
    if (tally_pos) begin
      stage_a = ST_ATTACK;
      level_a = '0;
    end else if (tally_neg) begin
      stage_a = ST_RELEASE;
    end

    lvl_x    = AW'(level_a);
    sus_raw  = AW'(cfg.sustain_level);
    sus_x    = (sus_raw > ONE_X) ? ONE_X : sus_raw;
    atk_sum  = lvl_x + AW'(cfg.attack_step);
    dec_diff = lvl_x - AW'(cfg.decay_step);
    rel_diff = lvl_x - AW'(cfg.release_step);

    stage_nxt = stage_a;
    level_nxt = level_a;
    case (stage_a)
      ST_ATTACK: begin
        if (atk_sum >= ONE_X) begin
          level_nxt = LVL_ONE;
          stage_nxt = ST_DECAY;
        end else begin
          level_nxt = atk_sum[LW-1:0];
        end
      end
      ST_DECAY: begin
        if (dec_diff <= sus_x) begin
          level_nxt = sus_x[LW-1:0];
          stage_nxt = ST_SUSTAIN;
        end else begin
          level_nxt = dec_diff[LW-1:0];
        end
      end
      ST_RELEASE: begin
        if (rel_diff <= 0) begin
          level_nxt = '0;
          stage_nxt = ST_IDLE;
        end else begin
          level_nxt = rel_diff[LW-1:0];
        end
      end
      default: begin
        level_nxt = level_a;
      end
    endcase
  end

  always_comb begin
    tally_nxt = tally_r;
    if (item_vld) begin
      tally_nxt = item_op ? tally_sat : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_IDLE;
      level_r <= '0;
      tally_r <= '0;
    end else begin
      tally_r <= tally_nxt;
      if (item_vld && !item_op) begin
        stage_r <= stage_nxt;
        level_r <= level_nxt;
      end
    end
  end

  assign mq_push   = item_vld && !item_op;
  assign mq_sample = item_sample;
  assign mq_code   = stage_code(stage_nxt);
  assign mq_level  = level_nxt;

`ifndef SYNTH
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_ONE)
    else $error("envelope level above one");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r == ST_IDLE |-> level_r == '0)
    else $error("idle stage with nonzero level");

  a_tally_clear: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && !item_op |=> tally_r == '0)
    else $error("note tally not cleared by sample");
`endif

endmodule

// ===== rtl/aeg_back.sv =====
// ----------------------------------------------------------------------------
// aeg_back
// Gain back end: takes queued samples, multiplies by the envelope level in a
// registered stage and hands the scaled sample to the result queue.
// ----------------------------------------------------------------------------
module aeg_back #(
  parameter int SAMPLE_BITS     = aeg_pkg::SAMPLE_BITS_DEF,
  parameter int LEVEL_FRAC_BITS = aeg_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            mq_empty,
  input  logic signed [SAMPLE_BITS-1:0]   mq_sample,
  input  logic [aeg_pkg::STAGE_W-1:0]     mq_code,
  input  logic [LEVEL_FRAC_BITS:0]        mq_level,
  output logic                            mq_pop,
  input  logic                            oq_full,
  output logic                            oq_push,
  output logic signed [SAMPLE_BITS-1:0]   oq_sample,
  output logic [aeg_pkg::STAGE_W-1:0]     oq_code,
  output logic [LEVEL_FRAC_BITS:0]        oq_level
);
  import aeg_pkg::*;

  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam int PW = SAMPLE_BITS + LW + 1;

  logic                      p_vld_r, p_vld_nxt;
  logic signed [PW-1:0]      prod_r;
  logic [STAGE_W-1:0]        code_r;
  logic [LW-1:0]             level_r;
  logic                      advance;
  logic signed [PW-1:0]      prod_sh;

  assign advance = !p_vld_r || !oq_full;
  assign mq_pop  = advance && !mq_empty;
  assign oq_push = p_vld_r && !oq_full;

  always_comb begin
    p_vld_nxt = p_vld_r;
    if (advance) begin
      p_vld_nxt = !mq_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= p_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      prod_r  <= PW'(mq_sample) * $signed({1'b0, mq_level});
      code_r  <= mq_code;
      level_r <= mq_level;
    end
  end

  assign prod_sh   = prod_r >>> LEVEL_FRAC_BITS;
  assign oq_sample = (code_r == CODE_IDLE) ? '0 : prod_sh[SAMPLE_BITS-1:0];
  assign oq_code   = code_r;
  assign oq_level  = level_r;

`ifndef SYNTH
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r && oq_full |=> p_vld_r && $stable(prod_r))
    else $error("product stage dropped a stalled item");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r && oq_full |-> !mq_pop)
    else $error("queue popped while product stage stalled");

  a_fill_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    mq_pop |=> p_vld_r)
    else $error("popped item missing from product stage");
`endif

endmodule

// ===== sim/tb_adsr_envelope_gain.sv =====
// ----------------------------------------------------------------------------
// tb_adsr_envelope_gain
// Self-checking bench for the ADSR envelope gain block. A queue-fed driver
// offers samples and MIDI messages while a clocked predictor tracks the note
// tally, stage and level. Each popped result is compared field by field with
// the oldest predicted gain result. The stimulus covers directed extremes,
// zero steps, sustain above unity, mixed note tallies and random note
// sequences under several register settings, with random idling and stalls.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_gain;
  import aeg_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int LF = LEVEL_FRAC_BITS_DEF;
  localparam logic [CFG_W-1:0] LEVEL_ONE = 1 << LF;

  typedef struct packed {
    logic          op;
    logic [SW-1:0] smp;
    logic [7:0]    status;
    logic [6:0]    vel;
    logic          done;
  } env_item_t;

  typedef struct packed {
    logic [SW-1:0]      smp;
    logic [STAGE_W-1:0] stg;
    logic [LF:0]        lvl;
  } gain_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_operation = 1'b0;
  logic signed [SW-1:0] in_sample_in = '0;
  logic [7:0] in_midi_status = '0;
  logic [6:0] in_midi_velocity = '0;
  logic in_message_complete = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [SW-1:0] out_sample_out;
  logic [STAGE_W-1:0] out_stage_out;
  logic [LF:0] out_level_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  env_item_t    pending_items[$];
  gain_result_t expected_gains[$];
  env_item_t    offered;
  gain_result_t want;

  logic [CFG_W-1:0]   env_cfg [4];
  logic [STAGE_W-1:0] env_stage = CODE_IDLE;
  longint             env_level = 0;
  int                 note_tally = 0;

  logic steady = 1'b0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   fails = 0;

  adsr_envelope_gain u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_operation        (in_operation),
    .in_sample_in        (in_sample_in),
    .in_midi_status      (in_midi_status),
    .in_midi_velocity    (in_midi_velocity),
    .in_message_complete (in_message_complete),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_sample_out      (out_sample_out),
    .out_stage_out       (out_stage_out),
    .out_level_out       (out_level_out),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_adsr_envelope_gain NOT OK");
    $finish;
  end

  task automatic advance_envelope(input env_item_t it);
    logic [7:0]   kind;
    int           delta;
    longint       nl;
    longint       sus;
    longint       prod;
    gain_result_t r;
    if (it.op) begin
      kind = it.status & MIDI_TYPE_MASK;
      delta = 0;
      if (it.done) begin
        if (kind == MIDI_NOTE_ON && it.vel != 0) delta = 1;
        else if (kind == MIDI_NOTE_OFF || kind == MIDI_NOTE_ON) delta = -2;
      end
      note_tally = note_tally + delta;
      if (note_tally > 32767) note_tally = 32767;
      if (note_tally < -32768) note_tally = -32768;
    end else begin
      if (note_tally > 0) begin
        env_stage = CODE_ATTACK;
        env_level = 0;
      end else if (note_tally < 0) begin
        env_stage = CODE_RELEASE;
      end
      note_tally = 0;
      sus = longint'(env_cfg[CFG_SUSTAIN_LEVEL]);
      if (sus > longint'(LEVEL_ONE)) sus = longint'(LEVEL_ONE);
      case (env_stage)
        CODE_ATTACK: begin
          env_level = env_level + longint'(env_cfg[CFG_ATTACK_STEP]);
          if (env_level >= longint'(LEVEL_ONE)) begin
            env_level = longint'(LEVEL_ONE);
            env_stage = CODE_DECAY;
          end
        end
        CODE_DECAY: begin
          nl = env_level - longint'(env_cfg[CFG_DECAY_STEP]);
          if (nl <= sus) begin
            env_level = sus;
            env_stage = CODE_SUSTAIN;
          end else begin
            env_level = nl;
          end
        end
        CODE_RELEASE: begin
          nl = env_level - longint'(env_cfg[CFG_RELEASE_STEP]);
          if (nl <= 0) begin
            env_level = 0;
            env_stage = CODE_IDLE;
          end else begin
            env_level = nl;
          end
        end
        default: begin
        end
      endcase
      prod = longint'(signed'(it.smp)) * env_level;
      r.smp = (env_stage == CODE_IDLE) ? '0 : SW'(prod >>> LF);
      r.stg = env_stage;
      r.lvl = env_level[LF:0];
      expected_gains.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) advance_envelope(offered);
      if (!in_push || !in_full) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
          offered = pending_items.pop_front();
          in_push <= 1'b1;
          in_operation <= offered.op;
          in_sample_in <= offered.smp;
          in_midi_status <= offered.status;
          in_midi_velocity <= offered.vel;
          in_message_complete <= offered.done;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_gains.size() == 0) begin
          $error("unexpected result: sample_out %0d stage_out %0d level_out %0d",
                 out_sample_out, out_stage_out, out_level_out);
          fails++;
        end else begin
          want = expected_gains.pop_front();
          if (out_sample_out !== want.smp) begin
            $error("sample_out: expected %0d, got %0d", $signed(want.smp), out_sample_out);
            fails++;
          end
          if (out_stage_out !== want.stg) begin
            $error("stage_out: expected %0d, got %0d", want.stg, out_stage_out);
            fails++;
          end
          if (out_level_out !== want.lvl) begin
            $error("level_out: expected %0d, got %0d", want.lvl, out_level_out);
            fails++;
          end
        end
      end
      if (hold_req && !hold_taken) begin
        hold_left = 400;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= steady || ($urandom_range(99) >= 33);
      end
    end
  end

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(9))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return SW'($urandom());
    endcase
  endfunction

  function automatic env_item_t sample_item(input logic [SW-1:0] s);
    env_item_t it;
    it.op = 1'b0;
    it.smp = s;
    it.status = 8'($urandom());
    it.vel = 7'($urandom());
    it.done = 1'($urandom());
    return it;
  endfunction

  function automatic env_item_t midi_item(input logic [7:0] status, input logic [6:0] vel,
                                          input logic done);
    env_item_t it;
    it.op = 1'b1;
    it.smp = SW'($urandom());
    it.status = status;
    it.vel = vel;
    it.done = done;
    return it;
  endfunction

  function automatic logic [CFG_W-1:0] rand_step();
    case ($urandom_range(5))
      0: return CFG_W'($urandom_range(LEVEL_ONE, 1));
      1: return CFG_W'($urandom());
      default: return (LEVEL_ONE >> $urandom_range(6, 1)) + CFG_W'($urandom_range(255));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    env_cfg[idx] = val;
  endtask

  task automatic write_envelope(input logic [CFG_W-1:0] att, input logic [CFG_W-1:0] dec,
                                input logic [CFG_W-1:0] sus, input logic [CFG_W-1:0] rel);
    write_reg(CFG_ATTACK_STEP, att);
    write_reg(CFG_DECAY_STEP, dec);
    write_reg(CFG_SUSTAIN_LEVEL, sus);
    write_reg(CFG_RELEASE_STEP, rel);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_push || expected_gains.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic add_notes(input int n);
    int         base;
    logic [7:0] ch;
    base = pending_items.size();
    while (pending_items.size() - base < n) begin
      ch = 8'($urandom_range(15));
      if ($urandom_range(99) < 70) begin
        pending_items.push_back(midi_item(MIDI_NOTE_ON | ch, 7'($urandom_range(127, 1)), 1'b1));
        if ($urandom_range(3) == 0)
          pending_items.push_back(midi_item(MIDI_NOTE_ON | ch, 7'($urandom_range(127, 1)), 1'b1));
        repeat ($urandom_range(30, 1)) pending_items.push_back(sample_item(rand_sample()));
        if ($urandom_range(1))
          pending_items.push_back(midi_item(MIDI_NOTE_OFF | ch, 7'($urandom()), 1'b1));
        else
          pending_items.push_back(midi_item(MIDI_NOTE_ON | ch, 7'd0, 1'b1));
        repeat ($urandom_range(30, 1)) pending_items.push_back(sample_item(rand_sample()));
      end else begin
        pending_items.push_back(midi_item(8'($urandom()), 7'($urandom()), 1'($urandom())));
        repeat ($urandom_range(3)) pending_items.push_back(sample_item(rand_sample()));
      end
    end
  endtask

  initial begin
    env_cfg[CFG_ATTACK_STEP] = ATTACK_STEP_RST;
    env_cfg[CFG_DECAY_STEP] = DECAY_STEP_RST;
    env_cfg[CFG_SUSTAIN_LEVEL] = SUSTAIN_LEVEL_RST;
    env_cfg[CFG_RELEASE_STEP] = RELEASE_STEP_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    pending_items.push_back(sample_item(24'h7FFFFF));
    pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd100, 1'b1));
    pending_items.push_back(sample_item(24'h800000));
    pending_items.push_back(midi_item(8'h9F, 7'd0, 1'b1));
    pending_items.push_back(sample_item(24'h7FFFFF));
    pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd127, 1'b0));
    pending_items.push_back(sample_item(24'hFFFFFF));
    pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd1, 1'b1));
    pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd1, 1'b1));
    pending_items.push_back(midi_item(8'h85, 7'd127, 1'b1));
    pending_items.push_back(sample_item(24'h000001));
    pending_items.push_back(midi_item(8'hF0, 7'd127, 1'b1));
    pending_items.push_back(midi_item(8'hB3, 7'd64, 1'b1));
    pending_items.push_back(sample_item(24'h400000));
    drain();

    write_envelope(LEVEL_ONE, 24'd1, 24'd0, LEVEL_ONE);
    pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd64, 1'b1));
    pending_items.push_back(sample_item(24'h7FFFFF));
    pending_items.push_back(sample_item(24'h800000));
    pending_items.push_back(midi_item(MIDI_NOTE_OFF, 7'd64, 1'b1));
    pending_items.push_back(sample_item(24'h7FFFFF));
    drain();

    write_envelope(24'd0, 24'd0, 24'hFFFFFF, 24'd0);
    pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd64, 1'b1));
    pending_items.push_back(sample_item(24'h7FFFFF));
    pending_items.push_back(midi_item(MIDI_NOTE_OFF, 7'd0, 1'b1));
    pending_items.push_back(sample_item(24'h7FFFFF));
    drain();

    write_reg(CFG_ATTACK_STEP, LEVEL_ONE);
    pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd64, 1'b1));
    pending_items.push_back(sample_item(24'h800000));
    pending_items.push_back(sample_item(24'h7FFFFF));
    pending_items.push_back(midi_item(MIDI_NOTE_OFF, 7'd64, 1'b1));
    pending_items.push_back(sample_item(24'h800000));
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 0) write_envelope(24'd1, LEVEL_ONE, LEVEL_ONE, 24'd1);
      else write_envelope(rand_step(), rand_step(), CFG_W'($urandom_range(LEVEL_ONE)),
                          rand_step());
      steady = (p == 1);
      if (p == 3) begin
        add_notes(60);
        drain();
        add_notes(60);
      end else begin
        add_notes(120);
      end
      if (p == 2) hold_req = 1'b1;
      drain();
      steady = 1'b0;
    end

    write_envelope(24'd65536, 24'd32768, 24'd2097152, 24'd16384);
    pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd64, 1'b1));
    pending_items.push_back(sample_item(rand_sample()));
    repeat (3) pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd64, 1'b1));
    repeat (2) pending_items.push_back(midi_item(MIDI_NOTE_OFF, 7'd64, 1'b1));
    pending_items.push_back(sample_item(rand_sample()));
    repeat (5) pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd64, 1'b1));
    repeat (2) pending_items.push_back(midi_item(MIDI_NOTE_OFF, 7'd64, 1'b1));
    pending_items.push_back(sample_item(rand_sample()));
    pending_items.push_back(sample_item(rand_sample()));
    repeat (4) pending_items.push_back(midi_item(MIDI_NOTE_OFF, 7'd64, 1'b1));
    repeat (8) pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd64, 1'b1));
    pending_items.push_back(sample_item(rand_sample()));
    pending_items.push_back(midi_item(MIDI_NOTE_ON, 7'd0, 1'b1));
    pending_items.push_back(sample_item(rand_sample()));
    pending_items.push_back(sample_item(rand_sample()));
    drain();

    if (fails == 0) $display("tb_adsr_envelope_gain OK");
    else $display("tb_adsr_envelope_gain NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aeg_pkg.sv
rtl/aeg_fifo.sv
rtl/aeg_front.sv
rtl/aeg_back.sv
rtl/adsr_envelope_gain.sv
sim/tb_adsr_envelope_gain.sv
